// ===== sv/baro_pkg.sv =====
// Package: payload types, register indexes, constants and saturation for the baro compensation.
`timescale 1ns / 1ps
package baro_pkg;

  localparam int PIPE_DEPTH = 11;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] COEF_SENS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] COEF_OFF      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] COEF_TCS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] COEF_TCO      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] COEF_TREF     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] COEF_TEMPSENS = 3'd5;

  localparam logic signed [19:0] TEMP_REF   = 20'sd2000;
  localparam logic signed [18:0] DLT_EXT    = -19'sd3500;
  localparam logic signed [19:0] EXT_OFFSET = 20'sd3500;
  localparam logic [23:0]        SCALE_K    = 24'd11567483;
  localparam logic signed [56:0] ROUND_HALF = 57'sd32768;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [23:0] raw_pressure;
    logic [23:0] raw_temperature;
  } baro_in_t;

  typedef struct packed {
    logic signed [18:0] temp_centi;
    logic signed [31:0] pressure_comp;
    logic signed [31:0] pressure_scaled;
    logic               low_temp;
  } baro_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/baro_sensor_compensation.sv =====
// Top level: pipelined barometric temperature and pressure compensation.
// Throughput: one request per cycle; each stage holds under stall and
// takes new data whenever it is empty or the stage after it advances.
// Reset: synchronous active-low rst_n clears all valid bits and the six
// calibration registers to zero; no request is in flight after reset.
`timescale 1ns / 1ps
module baro_sensor_compensation (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  baro_pkg::baro_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output baro_pkg::baro_out_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [baro_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);
  import baro_pkg::*;

  logic [15:0] c_sens_r, c_off_r, c_tcs_r, c_tco_r, c_tref_r, c_tsens_r;

  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_sens_r  <= '0;
      c_off_r   <= '0;
      c_tcs_r   <= '0;
      c_tco_r   <= '0;
      c_tref_r  <= '0;
      c_tsens_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        COEF_SENS:     c_sens_r  <= cfg_data;
        COEF_OFF:      c_off_r   <= cfg_data;
        COEF_TCS:      c_tcs_r   <= cfg_data;
        COEF_TCO:      c_tco_r   <= cfg_data;
        COEF_TREF:     c_tref_r  <= cfg_data;
        COEF_TEMPSENS: c_tsens_r <= cfg_data;
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < PIPE_DEPTH; g++) begin : g_en
      assign en[g] = out_ready || !(&vld_r[PIPE_DEPTH-1:g]);
    end
  endgenerate

  assign in_ready  = en[0];
  assign out_valid = vld_r[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // stage 1: dT
  logic [23:0]        s1_d1_r;
  logic signed [24:0] s1_dt_r, dt_nxt;
  assign dt_nxt = $signed({1'b0, in_data.raw_temperature}) - $signed({1'b0, c_tref_r, 8'b0});
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1_r <= in_data.raw_pressure;
      s1_dt_r <= dt_nxt;
    end
  end

  // stage 2: first-order products and the square of dT
  logic [23:0]        s2_d1_r;
  logic signed [41:0] s2_mt_r, s2_mo_r, s2_ms_r, mt_nxt, mo_nxt, ms_nxt;
  logic signed [49:0] s2_sq_r, sq_nxt;
  assign mt_nxt = s1_dt_r * $signed({1'b0, c_tsens_r});
  assign mo_nxt = s1_dt_r * $signed({1'b0, c_tco_r});
  assign ms_nxt = s1_dt_r * $signed({1'b0, c_tcs_r});
  assign sq_nxt = s1_dt_r * s1_dt_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_d1_r <= s1_d1_r;
      s2_mt_r <= mt_nxt;
      s2_mo_r <= mo_nxt;
      s2_ms_r <= ms_nxt;
      s2_sq_r <= sq_nxt;
    end
  end

  // stage 3: first-order TEMP, OFF, SENS and correction selects
  logic [23:0]        s3_d1_r;
  logic signed [18:0] s3_dlt_r, dlt_nxt;
  logic signed [19:0] s3_temp1_r, temp1_nxt, s3_e_r, e_nxt;
  logic signed [41:0] s3_off1_r, off1_nxt, s3_sens1_r, sens1_nxt;
  logic [17:0]        s3_t2_r, t2_nxt;
  logic               s3_low_r, low_nxt, s3_ext_r, ext_nxt;
  assign dlt_nxt   = $signed(s2_mt_r[41:23]);
  assign temp1_nxt = TEMP_REF + $signed({dlt_nxt[18], dlt_nxt});
  assign e_nxt     = $signed({dlt_nxt[18], dlt_nxt}) + EXT_OFFSET;
  assign off1_nxt  = $signed({10'b0, c_off_r, 16'b0})
                   + $signed({{7{s2_mo_r[41]}}, s2_mo_r[41:7]});
  assign sens1_nxt = $signed({11'b0, c_sens_r, 15'b0})
                   + $signed({{8{s2_ms_r[41]}}, s2_ms_r[41:8]});
  assign t2_nxt    = s2_sq_r[48:31];
  assign low_nxt   = dlt_nxt[18];
  assign ext_nxt   = dlt_nxt < DLT_EXT;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_d1_r    <= s2_d1_r;
      s3_dlt_r   <= dlt_nxt;
      s3_temp1_r <= temp1_nxt;
      s3_e_r     <= e_nxt;
      s3_off1_r  <= off1_nxt;
      s3_sens1_r <= sens1_nxt;
      s3_t2_r    <= t2_nxt;
      s3_low_r   <= low_nxt;
      s3_ext_r   <= ext_nxt;
    end
  end

  // stage 4: squares for the second-order terms
  logic [23:0]        s4_d1_r;
  logic signed [19:0] s4_temp1_r;
  logic signed [41:0] s4_off1_r, s4_sens1_r;
  logic [17:0]        s4_t2_r;
  logic               s4_low_r, s4_ext_r;
  logic signed [37:0] s4_a_r, a_nxt;
  logic signed [39:0] s4_b_r, b_nxt;
  assign a_nxt = s3_dlt_r * s3_dlt_r;
  assign b_nxt = s3_e_r * s3_e_r;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_d1_r    <= s3_d1_r;
      s4_temp1_r <= s3_temp1_r;
      s4_off1_r  <= s3_off1_r;
      s4_sens1_r <= s3_sens1_r;
      s4_t2_r    <= s3_t2_r;
      s4_low_r   <= s3_low_r;
      s4_ext_r   <= s3_ext_r;
      s4_a_r     <= a_nxt;
      s4_b_r     <= b_nxt;
    end
  end

  // stage 5: OFF2, SENS2 and final TEMP
  logic signed [41:0] a42, b42, a5, b7, b11;
  logic [23:0]        s5_d1_r;
  logic signed [41:0] s5_off1_r, s5_sens1_r, s5_off2_r, off2_nxt, s5_sens2_r, sens2_nxt;
  logic signed [20:0] s5_temp_r, temp_nxt;
  logic               s5_low_r;
  assign a42 = 42'(s4_a_r);
  assign b42 = 42'(s4_b_r);
  assign a5  = a42 + (a42 <<< 2);
  assign b7  = (b42 <<< 3) - b42;
  assign b11 = (b42 <<< 3) + (b42 <<< 1) + b42;
  assign off2_nxt  = (a5 >>> 1) + (s4_ext_r ? b7 : 42'sd0);
  assign sens2_nxt = (a5 >>> 2) + (s4_ext_r ? (b11 >>> 1) : 42'sd0);
  assign temp_nxt  = s4_low_r ? ($signed({s4_temp1_r[19], s4_temp1_r}) - $signed({3'b0, s4_t2_r}))
                              : $signed({s4_temp1_r[19], s4_temp1_r});
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_d1_r    <= s4_d1_r;
      s5_off1_r  <= s4_off1_r;
      s5_sens1_r <= s4_sens1_r;
      s5_off2_r  <= off2_nxt;
      s5_sens2_r <= sens2_nxt;
      s5_temp_r  <= temp_nxt;
      s5_low_r   <= s4_low_r;
    end
  end

  // stage 6: corrected OFF and SENS
  logic [23:0]        s6_d1_r;
  logic signed [41:0] s6_off_r, off_nxt, s6_sens_r, sens_nxt;
  logic signed [20:0] s6_temp_r;
  logic               s6_low_r;
  assign off_nxt  = s5_low_r ? (s5_off1_r - s5_off2_r) : s5_off1_r;
  assign sens_nxt = s5_low_r ? (s5_sens1_r - s5_sens2_r) : s5_sens1_r;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_d1_r   <= s5_d1_r;
      s6_off_r  <= off_nxt;
      s6_sens_r <= sens_nxt;
      s6_temp_r <= s5_temp_r;
      s6_low_r  <= s5_low_r;
    end
  end

  // stage 7: D1 * SENS as two partial products
  logic [43:0]        s7_pplo_r, pplo_nxt;
  logic signed [46:0] s7_pphi_r, pphi_nxt;
  logic signed [41:0] s7_off_r;
  logic signed [20:0] s7_temp_r;
  logic               s7_low_r;
  assign pplo_nxt = s6_d1_r * s6_sens_r[19:0];
  assign pphi_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[41:20]);
  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_pplo_r <= pplo_nxt;
      s7_pphi_r <= pphi_nxt;
      s7_off_r  <= s6_off_r;
      s7_temp_r <= s6_temp_r;
      s7_low_r  <= s6_low_r;
    end
  end

  // stage 8: combine partial products
  logic signed [63:0] s8_prod_r, prod_nxt;
  logic signed [41:0] s8_off_r;
  logic signed [20:0] s8_temp_r;
  logic               s8_low_r;
  assign prod_nxt = ($signed(64'(s7_pphi_r)) <<< 20) + $signed({20'b0, s7_pplo_r});
  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_prod_r <= prod_nxt;
      s8_off_r  <= s7_off_r;
      s8_temp_r <= s7_temp_r;
      s8_low_r  <= s7_low_r;
    end
  end

  // stage 9: P with saturation
  logic signed [43:0] x_w;
  logic signed [28:0] q_w;
  logic signed [31:0] s9_p_r, p_nxt;
  logic signed [20:0] s9_temp_r;
  logic               s9_low_r;
  assign x_w   = $signed({s8_prod_r[63], s8_prod_r[63:21]})
               - $signed({{2{s8_off_r[41]}}, s8_off_r});
  assign q_w   = $signed(x_w[43:15]);
  assign p_nxt = sat32(64'(q_w));
  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_p_r    <= p_nxt;
      s9_temp_r <= s8_temp_r;
      s9_low_r  <= s8_low_r;
    end
  end

  // stage 10: unit scaling product
  logic signed [56:0] s10_psm_r, psm_nxt;
  logic signed [31:0] s10_p_r;
  logic signed [20:0] s10_temp_r;
  logic               s10_low_r;
  assign psm_nxt = s9_p_r * $signed({1'b0, SCALE_K});
  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_psm_r  <= psm_nxt;
      s10_p_r    <= s9_p_r;
      s10_temp_r <= s9_temp_r;
      s10_low_r  <= s9_low_r;
    end
  end

  // stage 11: round, saturate, output register
  logic signed [56:0] pss_w;
  logic signed [40:0] sh_w;
  baro_out_t          out_data_r, out_nxt;
  assign pss_w = s10_psm_r + ROUND_HALF;
  assign sh_w  = $signed(pss_w[56:16]);
  always_comb begin
    out_nxt.temp_centi      = s10_temp_r[18:0];
    out_nxt.pressure_comp   = s10_p_r;
    out_nxt.pressure_scaled = sat32(64'(sh_w));
    out_nxt.low_temp        = s10_low_r;
  end
  always_ff @(posedge clk) begin
    if (en[10]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

endmodule

// ===== sv/baro_checker.sv =====
// Checker: port-level properties of the baro compensation, bound to the top level.
`timescale 1ns / 1ps
module baro_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input baro_pkg::baro_out_t out_data
);
  import baro_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result request present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result request changed or dropped");

  a_low_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.low_temp == (out_data.temp_centi < TEMP_REF)))
    else $error("low-temperature flag disagrees with temperature");

  a_scaled_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pressure_comp[31] == out_data.pressure_scaled[31]))
    else $error("scaled pressure sign differs from pressure sign");

endmodule

bind baro_sensor_compensation baro_checker u_baro_checker (.*);

// ===== dv/tb_baro_sensor_compensation.sv =====
// Testbench: drives raw conversion pairs and calibration words, checks every compensated result.
`timescale 1ns / 1ps
module tb_baro_sensor_compensation;
  import baro_pkg::*;

  localparam int NUM_CAL        = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 7;
  localparam int PHASE_ITEMS    = 200;

  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  localparam longint TEMP_KNEE  = 2000;
  localparam longint TEMP_COLD  = -1500;
  localparam longint PA_SCALE_MUL = 11567483;
  localparam longint PA_ROUND   = 32768;
  localparam longint D_MAX      = 24'hFFFFFF;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  baro_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  baro_out_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  logic [NUM_CAL-1:0][15:0] cal;
  baro_out_t                pending_results[$];
  baro_out_t                want;
  int                       mismatches;
  int                       quiet_cycles;
  bit                       idle_on;

  baro_sensor_compensation dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint clip32(input longint v);
    longint r;
    r = v;
    if (v > 64'sd2147483647) begin
      r = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      r = -64'sd2147483648;
    end
    return r;
  endfunction

  function automatic baro_out_t compensate(input baro_in_t r);
    longint    d1, d2, c1, c2, c3, c4, c5, c6;
    longint    dt, t, off, sens, t2, a, b, off2, sens2, p, ps;
    baro_out_t o;
    d1 = r.raw_pressure;
    d2 = r.raw_temperature;
    c1 = cal[COEF_SENS];
    c2 = cal[COEF_OFF];
    c3 = cal[COEF_TCS];
    c4 = cal[COEF_TCO];
    c5 = cal[COEF_TREF];
    c6 = cal[COEF_TEMPSENS];
    dt   = d2 - c5 * 256;
    t    = TEMP_KNEE + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    o.low_temp = 1'b0;
    if (t < TEMP_KNEE) begin
      t2    = (dt * dt) >>> 31;
      a     = (t - TEMP_KNEE) * (t - TEMP_KNEE);
      off2  = (5 * a) >>> 1;
      sens2 = (5 * a) >>> 2;
      if (t < TEMP_COLD) begin
        b     = (t - TEMP_COLD) * (t - TEMP_COLD);
        off2  = off2 + 7 * b;
        sens2 = sens2 + ((11 * b) >>> 1);
      end
      t    = t - t2;
      off  = off - off2;
      sens = sens - sens2;
      o.low_temp = 1'b1;
    end
    p  = clip32((((d1 * sens) >>> 21) - off) >>> 15);
    ps = clip32((p * PA_SCALE_MUL + PA_ROUND) >>> 16);
    o.temp_centi      = t[18:0];
    o.pressure_comp   = p[31:0];
    o.pressure_scaled = ps[31:0];
    return o;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, exp_v, $realtime);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index < NUM_CAL) begin
        cal[cfg_index] = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.temp_centi !== want.temp_centi)
            report_mismatch("temp_centi", longint'(out_data.temp_centi),
                            longint'(want.temp_centi));
          if (out_data.pressure_comp !== want.pressure_comp)
            report_mismatch("pressure_comp", longint'(out_data.pressure_comp),
                            longint'(want.pressure_comp));
          if (out_data.pressure_scaled !== want.pressure_scaled)
            report_mismatch("pressure_scaled", longint'(out_data.pressure_scaled),
                            longint'(want.pressure_scaled));
          if (out_data.low_temp !== want.low_temp)
            report_mismatch("low_temp", longint'(out_data.low_temp),
                            longint'(want.low_temp));
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(compensate(in_data));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_baro_sensor_compensation NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        burst = $urandom_range(1, 13);
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_conversion(input logic [23:0] d1, input logic [23:0] d2);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{raw_pressure: d1, raw_temperature: d2};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_coefs(input logic [NUM_CAL-1:0][15:0] set);
    for (int i = 0; i < NUM_CAL; i++) begin
      write_coef(CFG_IDX_W'(i), set[i]);
    end
  endtask

  function automatic logic [NUM_CAL-1:0][15:0] datasheet_coefs();
    logic [NUM_CAL-1:0][15:0] set;
    set[COEF_SENS]     = 16'd40127;
    set[COEF_OFF]      = 16'd36924;
    set[COEF_TCS]      = 16'd23317;
    set[COEF_TCO]      = 16'd23282;
    set[COEF_TREF]     = 16'd33464;
    set[COEF_TEMPSENS] = 16'd28312;
    return set;
  endfunction

  function automatic logic [23:0] temp_at(input longint dt);
    longint d2;
    d2 = longint'(cal[COEF_TREF]) * 256 + dt;
    if (d2 < 0) d2 = 0;
    if (d2 > D_MAX) d2 = D_MAX;
    return d2[23:0];
  endfunction

  task automatic test_reset_values();
    send_conversion(24'h000000, 24'h000000);
    send_conversion(24'hFFFFFF, 24'hFFFFFF);
    send_conversion(24'hFFFFFF, 24'h000000);
    send_conversion(24'h000000, 24'hFFFFFF);
    wait_drained();
  endtask

  task automatic test_coef_extremes();
    load_coefs({NUM_CAL{16'hFFFF}});
    send_conversion(24'hFFFFFF, 24'hFFFFFF);
    send_conversion(24'h000000, 24'h000000);
    send_conversion(24'hFFFFFF, 24'h000000);
    send_conversion(24'h000000, 24'hFFFFFF);
    wait_drained();
  endtask

  task automatic test_ignored_index();
    load_coefs(datasheet_coefs());
    write_coef(IDX_UNUSED_LO, 16'hFFFF);
    write_coef(IDX_UNUSED_HI, 16'hFFFF);
    send_conversion(24'd9085466, temp_at(0));
    send_conversion(24'hFFFFFF, temp_at(-2000000));
    wait_drained();
  endtask

  task automatic test_second_order();
    load_coefs(datasheet_coefs());
    send_conversion(24'd9085466, temp_at(0));
    send_conversion(24'd9085466, temp_at(-1));
    send_conversion(24'd9085466, temp_at(1000000));
    send_conversion(24'd9085466, temp_at(-500000));
    send_conversion(24'd9085466, temp_at(-2000000));
    send_conversion(24'hABCDEF, 24'h000000);
    send_conversion(24'h123456, 24'hFFFFFF);
    wait_drained();
  endtask

  task automatic test_pressure_saturation();
    logic [NUM_CAL-1:0][15:0] set;
    set = {NUM_CAL{16'hFFFF}};
    set[COEF_OFF] = 16'h0000;
    set[COEF_TCO] = 16'h0000;
    load_coefs(set);
    send_conversion(24'hFFFFFF, 24'h000000);
    send_conversion(24'hFFFFFF, 24'h000100);
    wait_drained();
  endtask

  function automatic logic [NUM_CAL-1:0][15:0] random_coefs(input int kind);
    logic [NUM_CAL-1:0][15:0] set;
    logic [NUM_CAL-1:0][15:0] base;
    base = datasheet_coefs();
    for (int i = 0; i < NUM_CAL; i++) begin
      case (kind)
        0: set[i] = base[i] + 16'($urandom_range(0, 8191)) - 16'd4096;
        1: set[i] = 16'($urandom_range(0, 65535));
        default: begin
          case ($urandom_range(0, 2))
            0: set[i] = 16'h0000;
            1: set[i] = 16'hFFFF;
            default: set[i] = 16'($urandom_range(0, 65535));
          endcase
        end
      endcase
    end
    return set;
  endfunction

  function automatic longint random_offset();
    longint dt;
    case ($urandom_range(0, 9))
      0, 1: dt = longint'($urandom_range(0, 24'hFFFFFF)) - longint'(cal[COEF_TREF]) * 256;
      2, 3: dt = longint'($urandom_range(0, 131072)) - 65536;
      4, 5: dt = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
      default: dt = -longint'($urandom_range(0, 1 << 23));
    endcase
    return dt;
  endfunction

  task automatic test_random_settings();
    logic [23:0] d1;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph < RANDOM_PHASES - 1);
      load_coefs(random_coefs(ph % 3));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 15))
          0: d1 = 24'h000000;
          1: d1 = 24'hFFFFFF;
          default: d1 = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        send_conversion(d1, temp_at(random_offset()));
      end
      wait_drained();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    cal        = '0;
    mismatches = 0;
    quiet_cycles = 0;
    idle_on    = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_coef_extremes();
    test_ignored_index();
    test_second_order();
    test_pressure_saturation();
    test_random_settings();

    wait_drained();
    repeat (PIPE_DEPTH + 4) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_baro_sensor_compensation OK");
    end else begin
      $display("tb_baro_sensor_compensation NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/baro_pkg.sv
sv/baro_sensor_compensation.sv
sv/baro_checker.sv
dv/tb_baro_sensor_compensation.sv
